@@ hdl/idc_pkg.sv @@
// ----------------------------------------------------------------------------
// idc_pkg
// Shared types and constants of the ISO 8601 duration checker.
// ----------------------------------------------------------------------------
`default_nettype none

package idc_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_NO_P     = 2'd2;
  localparam logic [1:0] STATUS_MISMATCH = 2'd3;

  // Last designator seen
  localparam logic [3:0] STAGE_NONE   = 4'd0;
  localparam logic [3:0] STAGE_YEAR   = 4'd1;
  localparam logic [3:0] STAGE_MONTH  = 4'd2;
  localparam logic [3:0] STAGE_WEEK   = 4'd3;
  localparam logic [3:0] STAGE_DAY    = 4'd4;
  localparam logic [3:0] STAGE_TIME   = 4'd5;
  localparam logic [3:0] STAGE_HOUR   = 4'd6;
  localparam logic [3:0] STAGE_MINUTE = 4'd7;
  localparam logic [3:0] STAGE_SECOND = 4'd8;

  // ASCII characters of interest
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_Y = 8'h59;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_W = 8'h57;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_H = 8'h48;
  localparam logic [7:0] CHAR_S = 8'h53;

  typedef struct packed {
    logic       at_first;
    logic [3:0] stage;
    logic       digits_pending;
    logic       need_digit;
    logic [1:0] error_code;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    at_first:       1'b1,
    stage:          STAGE_NONE,
    digits_pending: 1'b0,
    need_digit:     1'b0,
    error_code:     STATUS_OK
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } step_result_t;

endpackage : idc_pkg

`default_nettype wire

@@ hdl/iso8601_duration_checker_core.sv @@
// ----------------------------------------------------------------------------
// iso8601_duration_checker_core
// Streams an ISO 8601 duration string one character per transaction and
// returns one status per string (ok, empty, missing P, mismatch).
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata             | tlast    | tuser
//  --------+-----------+-------------------+----------+---------
//  in_     | slave     | [7:0] char_code   | is_last  | is_empty
//  out_    | master    | [1:0] status      | -        | -
//
//  One character per cycle sustained while no status waits on a stalled out_.
//  The status passes through the input register, then the result register,
//  before it goes out on out_.
//  Only a character marked last, or an empty transaction, yields a status.
//  rst_n is synchronous, active low: it drops both register stages and puts
//  the parser state back to "expecting the first character".
//  A stalled result holds in the output register; the input stage keeps
//  advancing while its item yields no status or the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module iso8601_duration_checker_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,
  input  logic       in_tuser,   // [0] is_empty
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] status, [7:2] zero
);
  import idc_pkg::*;

  // Input register stage
  logic         in_valid_r;
  logic [7:0]   char_r;
  logic         last_r;
  logic         empty_r;

  // Parser state and result register
  parse_state_t state_r;
  parse_state_t state_nxt;
  step_result_t step_res;
  logic         out_valid_r;
  logic [1:0]   status_r;

  logic         out_free;
  logic         advance;

  idc_step u_step (
    .cur_state (state_r),
    .char_code (char_r),
    .is_last   (last_r),
    .is_empty  (empty_r),
    .nxt_state (state_nxt),
    .result    (step_res)
  );

  // Result register can take a new status when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  // Retire the held item unless its status would overwrite a stalled one.
  assign advance   = in_valid_r && (!step_res.valid || out_free);
  assign in_tready = !in_valid_r || advance;

  // Capture a new transaction whenever the input stage is free or retiring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r  <= in_tdata;
      last_r  <= in_tlast;
      empty_r <= in_tuser;
    end
  end

  // Advance the parser state once per retired character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PARSE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Load the status on a retiring item that yields one; drop it when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      status_r <= step_res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, status_r};

endmodule : iso8601_duration_checker_core

`default_nettype wire

@@ hdl/idc_step.sv @@
// ----------------------------------------------------------------------------
// idc_step
// Next-state and status logic for one character of a duration string.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_step (
  input  idc_pkg::parse_state_t cur_state,
  input  logic [7:0]            char_code,
  input  logic                  is_last,
  input  logic                  is_empty,
  output idc_pkg::parse_state_t nxt_state,
  output idc_pkg::step_result_t result
);
  import idc_pkg::*;

  function automatic logic [3:0] rank_of(input logic [7:0] c, input logic [3:0] cur);
    logic [3:0] r;
    r = STAGE_NONE;
    if (cur < STAGE_TIME) begin
      case (c)
        CHAR_Y:  r = STAGE_YEAR;
        CHAR_M:  r = STAGE_MONTH;
        CHAR_W:  r = STAGE_WEEK;
        CHAR_D:  r = STAGE_DAY;
        default: r = STAGE_NONE;
      endcase
    end else begin
      case (c)
        CHAR_H:  r = STAGE_HOUR;
        CHAR_M:  r = STAGE_MINUTE;
        CHAR_S:  r = STAGE_SECOND;
        default: r = STAGE_NONE;
      endcase
    end
    return r;
  endfunction

  parse_state_t s;
  logic         lone_p;
  logic         is_digit;
  logic [3:0]   rank;

  assign is_digit = (char_code >= CHAR_0) && (char_code <= CHAR_9);
  assign rank     = rank_of(char_code, cur_state.stage);

  always_comb begin
    s             = cur_state;
    lone_p        = 1'b0;
    result.valid  = 1'b0;
    result.status = STATUS_OK;
    if (is_empty) begin
      s             = PARSE_RESET;
      result.valid  = 1'b1;
      result.status = STATUS_EMPTY;
    end else begin
      if (cur_state.at_first) begin
        s.at_first = 1'b0;
        if (char_code != CHAR_P) begin
          s.error_code = STATUS_NO_P;
        end else begin
          lone_p = 1'b1;
        end
      end else if (cur_state.error_code == STATUS_OK) begin
        if (is_digit) begin
          s.digits_pending = 1'b1;
          s.need_digit     = 1'b0;
        end else if (cur_state.need_digit) begin
          s.error_code = STATUS_MISMATCH;
        end else if (char_code == CHAR_T) begin
          if (cur_state.stage <= STAGE_DAY && !cur_state.digits_pending) begin
            s.stage      = STAGE_TIME;
            s.need_digit = 1'b1;
          end else begin
            s.error_code = STATUS_MISMATCH;
          end
        end else if (rank != STAGE_NONE && rank > cur_state.stage &&
                     cur_state.digits_pending) begin
          s.stage          = rank;
          s.digits_pending = 1'b0;
        end else begin
          s.error_code = STATUS_MISMATCH;
        end
      end
      if (is_last) begin
        result.valid = 1'b1;
        if (s.error_code != STATUS_OK) begin
          result.status = s.error_code;
        end else if (lone_p || s.digits_pending || s.need_digit) begin
          result.status = STATUS_MISMATCH;
        end else begin
          result.status = STATUS_OK;
        end
        s = PARSE_RESET;
      end
    end
  end

  assign nxt_state = s;

endmodule : idc_step

`default_nettype wire

@@ tb/tb_iso8601_duration_checker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso8601_duration_checker_core
// Streams duration strings into the checker one character per transaction and
// compares every status word against a cycle-free model of the parser. Mostly
// well-formed strings with random digit runs, plus corrupted, truncated,
// aborted and noise strings. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------

module tb_iso8601_duration_checker_core;
  import idc_pkg::*;

  localparam int unsigned ITEM_TARGET = 950;
  // Bound on the run length, with plenty of margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // --------------------------------------------------------------------------
  // Status model: tracks the parser state and queues the status each string
  // must produce. Fed at input acceptance, drained at output acceptance.
  // --------------------------------------------------------------------------
  class duration_scoreboard;
    logic       at_first;
    logic [3:0] stage;
    logic       digits_pending;
    logic       need_digit;
    logic [1:0] err_code;
    logic [1:0] status_q[$];
    int unsigned fail_cnt;

    function new();
      fail_cnt = 0;
      restart();
    endfunction

    function void restart();
      at_first       = 1'b1;
      stage          = STAGE_NONE;
      digits_pending = 1'b0;
      need_digit     = 1'b0;
      err_code       = STATUS_OK;
    endfunction

    // Advance the parser by one accepted character and queue a status when
    // the string ends (last character or empty transaction).
    function void note_char(logic [7:0] ch, logic last, logic empty);
      logic       lone_p;
      logic [3:0] rank;
      lone_p = 1'b0;
      rank   = STAGE_NONE;
      if (empty) begin
        // An empty transaction drops any partial string.
        restart();
        status_q.push_back(STATUS_EMPTY);
        return;
      end
      if (at_first) begin
        at_first = 1'b0;
        if (ch != CHAR_P) begin
          err_code = STATUS_NO_P;
        end else begin
          lone_p = 1'b1;
        end
      end else if (err_code == STATUS_OK) begin
        // After the first error everything up to the end is ignored.
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
          digits_pending = 1'b1;
          need_digit     = 1'b0;
        end else if (need_digit) begin
          err_code = STATUS_MISMATCH;
        end else if (ch == CHAR_T) begin
          if (stage <= STAGE_DAY && !digits_pending) begin
            stage      = STAGE_TIME;
            need_digit = 1'b1;
          end else begin
            err_code = STATUS_MISMATCH;
          end
        end else begin
          // M means month in the date part and minute in the time part.
          if (stage < STAGE_TIME) begin
            case (ch)
              CHAR_Y:  rank = STAGE_YEAR;
              CHAR_M:  rank = STAGE_MONTH;
              CHAR_W:  rank = STAGE_WEEK;
              CHAR_D:  rank = STAGE_DAY;
              default: rank = STAGE_NONE;
            endcase
          end else begin
            case (ch)
              CHAR_H:  rank = STAGE_HOUR;
              CHAR_M:  rank = STAGE_MINUTE;
              CHAR_S:  rank = STAGE_SECOND;
              default: rank = STAGE_NONE;
            endcase
          end
          if (rank != STAGE_NONE && rank > stage && digits_pending) begin
            stage          = rank;
            digits_pending = 1'b0;
          end else begin
            err_code = STATUS_MISMATCH;
          end
        end
      end
      if (last) begin
        if (err_code != STATUS_OK) begin
          status_q.push_back(err_code);
        end else if (lone_p || digits_pending || need_digit) begin
          status_q.push_back(STATUS_MISMATCH);
        end else begin
          status_q.push_back(STATUS_OK);
        end
        restart();
      end
    endfunction

    // Compare one accepted output word with the oldest queued status.
    function void check_status(logic [7:0] word);
      logic [1:0] want;
      if (status_q.size() == 0) begin
        $error("status: expected none, actual %0d", word[1:0]);
        fail_cnt++;
        return;
      end
      want = status_q.pop_front();
      if (word[1:0] !== want) begin
        $error("status: expected %0d, actual %0d", want, word[1:0]);
        fail_cnt++;
      end
      if (word[7:2] !== 6'd0) begin
        $error("pad: expected 0, actual %0h", word[7:2]);
        fail_cnt++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] char_code
  logic       in_tlast   = 1'b0;
  logic       in_tuser   = 1'b0;   // [0] is_empty
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [1:0] status, [7:2] zero

  // No random stalls on either side while calm is set.
  bit          calm      = 1'b0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  logic [7:0]  text_q[$];

  duration_scoreboard sb = new();

  always #2 clk = ~clk;

  iso8601_duration_checker_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Result side: stall at random, check every accepted status word.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_status(out_tdata);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Drive one transaction. Entered and left at a falling edge; tvalid is left
  // high so back-to-back transactions need no extra assignment.
  task automatic send_item(input logic [7:0] ch, input logic last, input logic empty);
    while (!calm && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    in_tuser  <= empty;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(ch, last, empty);
    sent_cnt++;
    @(negedge clk);
  endtask

  // Send the buffered string, marking its final character.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], i == text_q.size() - 1, 1'b0);
    end
  endtask

  // Hold off the input until every queued status has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.status_q.size() != 0) @(negedge clk);
  endtask

  // Append a digit run followed by its designator.
  task automatic add_component(input logic [7:0] designator);
    repeat ($urandom_range(3, 1)) text_q.push_back(CHAR_0 + 8'($urandom_range(9)));
    text_q.push_back(designator);
  endtask

  // Build a well-formed duration with a random set of components.
  task automatic build_duration();
    bit any_date;
    bit use_time;
    bit any_time;
    any_date = 1'b0;
    any_time = 1'b0;
    text_q.delete();
    text_q.push_back(CHAR_P);
    if ($urandom_range(1)) begin add_component(CHAR_Y); any_date = 1'b1; end
    if ($urandom_range(1)) begin add_component(CHAR_M); any_date = 1'b1; end
    if ($urandom_range(1)) begin add_component(CHAR_W); any_date = 1'b1; end
    if ($urandom_range(1)) begin add_component(CHAR_D); any_date = 1'b1; end
    use_time = 1'($urandom_range(1));
    if (!any_date && !use_time) begin
      add_component(CHAR_D);
    end
    if (use_time) begin
      text_q.push_back(CHAR_T);
      if ($urandom_range(1)) begin add_component(CHAR_H); any_time = 1'b1; end
      if ($urandom_range(1)) begin add_component(CHAR_M); any_time = 1'b1; end
      if ($urandom_range(1)) begin add_component(CHAR_S); any_time = 1'b1; end
      if (!any_time) add_component(CHAR_S);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned cut;
    int unsigned next_drain;
    next_drain = 250;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: shortcut forms, month vs. minute, lone P, empty items,
    // missing P with trailing P, bad character, string aborted by empty.
    text_q = {CHAR_P, CHAR_0, CHAR_D};
    send_text();
    text_q = {CHAR_P, CHAR_T, CHAR_0, CHAR_M};
    send_text();
    text_q = {CHAR_P, CHAR_0, CHAR_Y, CHAR_0, CHAR_M, CHAR_0, CHAR_D};
    send_text();
    text_q = {CHAR_P};
    send_text();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    text_q = {8'h00};
    send_text();
    text_q = {8'hFF, CHAR_P};
    send_text();
    text_q = {CHAR_P, 8'h00};
    send_text();
    send_item(CHAR_P, 1'b0, 1'b0);
    send_item(CHAR_0 + 8'd1, 1'b0, 1'b0);
    send_item(CHAR_D, 1'b1, 1'b1);

    // Let the pipeline empty once before the random part.
    drain_results();

    while (sent_cnt < ITEM_TARGET) begin
      // Long stretch with no stalls on either side.
      calm = (sent_cnt >= 400 && sent_cnt < 560);
      if (sent_cnt >= next_drain) begin
        drain_results();
        next_drain += 250;
      end
      kind = $urandom_range(99);
      build_duration();
      if (kind < 58) begin
        // keep well-formed
      end else if (kind < 68) begin
        // corrupt one character after the P
        text_q[$urandom_range(text_q.size() - 1, 1)] = 8'($urandom_range(255));
      end else if (kind < 74) begin
        text_q.delete($urandom_range(text_q.size() - 1, 1));
      end else if (kind < 80) begin
        // random bytes, sometimes behind a valid prefix character
        text_q.delete();
        repeat ($urandom_range(5, 1)) text_q.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) text_q[0] = CHAR_P;
      end else if (kind < 85) begin
        text_q[0] = 8'($urandom_range(255));
      end else if (kind < 90) begin
        // truncate: may leave dangling digits or T
        cut = $urandom_range(text_q.size() - 1, 1);
        repeat (cut) void'(text_q.pop_back());
      end else if (kind < 94) begin
        text_q = {CHAR_P};
        if ($urandom_range(1)) text_q.push_back(CHAR_T);
      end else begin
        // abort a partial string with an empty transaction
        cut = $urandom_range(text_q.size());
        for (int i = 0; i < cut; i++) send_item(text_q[i], 1'b0, 1'b0);
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        continue;
      end
      send_text();
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/idc_pkg.sv
hdl/idc_step.sv
hdl/iso8601_duration_checker_core.sv
tb/tb_iso8601_duration_checker_core.sv
